>>> design/chth_pkg.sv
`timescale 1ns / 1ps
package chth_pkg;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned LinkW    = IdxW + 1;
  localparam int unsigned CountW   = IdxW + 1;

  typedef logic [LinkW-1:0] link_t;

  localparam link_t EmptyLink = {LinkW{1'b1}};

  localparam logic [1:0] ReqAppend = 2'd0;
  localparam logic [1:0] ReqRemove = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [1:0] StatDone     = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatNotFound = 2'd2;

  // True when a link names a real pool node.
  function automatic logic link_valid(link_t l);
    return l < link_t'(Capacity);
  endfunction

endpackage

>>> design/chained_hash_table_insert_remove_core.sv
`timescale 1ns / 1ps
// Chained hash table core: append, remove and clear of 32-bit key/value pairs.
//
// The request channel (req_valid_i / req_stall_o) carries a request type, a
// key and a value. The result channel (rsp_valid_o / rsp_stall_i) returns one
// result for every request: a status, the pool node used by an append, and
// the number of stored pairs after the request. A request is taken when valid
// is high and stall is low.
//
// Requests are handled one at a time by a small sequencer around one
// single-port RAM per table array. An append reads the bucket head and then
// links the free node in front of it; a rejected append or an unused request
// code goes straight to the result. A remove reads the bucket head and walks
// the chain; a matching node is unlinked and returned to the free list.
// Each node visited costs a link/key read and a compare. A clear sweeps all
// Capacity entries, one per cycle, and answers when the sweep is done.
// The next request can be taken in the cycle after the result is accepted.
// After reset the same sweep runs over all entries before the first
// request is accepted. While a result waits because the receiver stalls, it
// stays in the output register and no new request is taken.
module chained_hash_table_insert_remove_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [1:0]  status_o,
  output logic [9:0]  node_index_o,
  output logic [10:0] entry_count_o
);

  localparam int unsigned IdxW  = chth_pkg::IdxW;
  localparam int unsigned LinkW = chth_pkg::LinkW;

  typedef enum logic [3:0] {
    StSweep, StIdle, StAppRd, StAppWr, StRemRd, StRemHead, StRemNode,
    StRemCheck, StRemUnlink, StRemFree, StResp
  } state_e;

  state_e state_q;

  // Memory ports (each array has its own RAM).
  logic               bh_we, nl_we, nk_we;
  logic [IdxW-1:0]    bh_addr, nl_addr, nk_addr;
  chth_pkg::link_t    bh_wdata, nl_wdata, bh_rdata, nl_rdata;
  logic [31:0]        nk_wdata, nk_rdata;
  logic               nv_we;
  logic [31:0]        nv_wdata, nv_rdata;

  chth_ram #(.Depth(chth_pkg::Capacity), .Width(LinkW)) u_bh (
    .clk_i, .we_i(bh_we), .addr_i(bh_addr), .wdata_i(bh_wdata), .rdata_o(bh_rdata));
  chth_ram #(.Depth(chth_pkg::Capacity), .Width(LinkW)) u_nl (
    .clk_i, .we_i(nl_we), .addr_i(nl_addr), .wdata_i(nl_wdata), .rdata_o(nl_rdata));
  chth_ram #(.Depth(chth_pkg::Capacity), .Width(32)) u_nk (
    .clk_i, .we_i(nk_we), .addr_i(nk_addr), .wdata_i(nk_wdata), .rdata_o(nk_rdata));
  // Values are written but never read back by any request.
  chth_ram #(.Depth(chth_pkg::Capacity), .Width(32)) u_nv (
    .clk_i, .we_i(nv_we), .addr_i(nk_addr), .wdata_i(nv_wdata), .rdata_o(nv_rdata));

  logic [IdxW-1:0]       sweep_q;
  logic [1:0]            req_q;
  logic [31:0]           key_q, val_q;
  chth_pkg::link_t       free_q, cur_q, prev_q, next_q;
  logic [IdxW:0]         steps_q;
  logic [chth_pkg::CountW-1:0] count_q;
  logic [1:0]            status_q;
  logic [IdxW-1:0]       node_q;
  logic                  sweep_last;
  logic [IdxW-1:0]       bucket;

  assign bucket     = key_q[IdxW-1:0];
  assign sweep_last = (sweep_q == IdxW'(chth_pkg::Capacity - 1));

  always_comb begin
    bh_we = 1'b0; nl_we = 1'b0; nk_we = 1'b0; nv_we = 1'b0;
    bh_addr = bucket; nl_addr = cur_q[IdxW-1:0]; nk_addr = cur_q[IdxW-1:0];
    bh_wdata = chth_pkg::EmptyLink; nl_wdata = next_q; nk_wdata = 32'd0;
    nv_wdata = 32'd0;
    case (state_q)
      StSweep: begin
        bh_we = 1'b1; nl_we = 1'b1; nk_we = 1'b1; nv_we = 1'b1;
        bh_addr = sweep_q; nl_addr = sweep_q; nk_addr = sweep_q;
        nl_wdata = sweep_last ? chth_pkg::EmptyLink : LinkW'(sweep_q) + 1'b1;
      end
      StAppRd: begin
        nl_addr = free_q[IdxW-1:0];
      end
      StAppWr: begin
        // Read of the bucket head finished; link the free node in front.
        bh_we = 1'b1; bh_wdata = free_q;
        nl_we = 1'b1; nl_addr = free_q[IdxW-1:0]; nl_wdata = bh_rdata;
        nk_we = 1'b1; nk_addr = free_q[IdxW-1:0]; nk_wdata = key_q;
        nv_we = 1'b1; nv_wdata = val_q;
      end
      StRemUnlink: begin
        if (chth_pkg::link_valid(prev_q)) begin
          nl_we = 1'b1; nl_addr = prev_q[IdxW-1:0]; nl_wdata = next_q;
        end else begin
          bh_we = 1'b1; bh_wdata = next_q;
        end
      end
      StRemFree: begin
        nl_we = 1'b1; nl_wdata = free_q;
        nk_we = 1'b1; nv_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StSweep;
      sweep_q  <= '0;
      free_q   <= '0;
      count_q  <= '0;
      req_q    <= '0;
      key_q    <= '0;
      val_q    <= '0;
      cur_q    <= '0;
      prev_q   <= '0;
      next_q   <= '0;
      steps_q  <= '0;
      status_q <= chth_pkg::StatDone;
      node_q   <= '0;
    end else begin
      case (state_q)
        StSweep: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_last) begin
            free_q  <= '0;
            count_q <= '0;
            state_q <= (req_q == chth_pkg::ReqClear) ? StResp : StIdle;
            req_q   <= '0;
          end
        end
        StIdle: begin
          if (req_valid_i) begin
            req_q <= req_type_i; key_q <= key_i; val_q <= value_i;
            status_q <= chth_pkg::StatDone; node_q <= '0;
            case (req_type_i)
              chth_pkg::ReqAppend: begin
                if (chth_pkg::link_valid(free_q)) begin
                  state_q <= StAppRd;
                end else begin
                  status_q <= chth_pkg::StatFull;
                  state_q  <= StResp;
                end
              end
              chth_pkg::ReqRemove: state_q <= StRemRd;
              chth_pkg::ReqClear: begin
                sweep_q <= '0;
                state_q <= StSweep;
              end
              default: state_q <= StResp;
            endcase
          end
        end
        StAppRd: state_q <= StAppWr;
        StAppWr: begin
          free_q  <= nl_rdata;
          node_q  <= free_q[IdxW-1:0];
          count_q <= count_q + 1'b1;
          state_q <= StResp;
        end
        StRemRd: begin
          prev_q  <= chth_pkg::EmptyLink;
          steps_q <= '0;
          state_q <= StRemHead;
        end
        StRemHead: begin
          cur_q   <= bh_rdata;
          state_q <= StRemNode;
        end
        StRemNode: begin
          if (!chth_pkg::link_valid(cur_q) || steps_q >= (IdxW+1)'(chth_pkg::Capacity)) begin
            status_q <= chth_pkg::StatNotFound;
            state_q  <= StResp;
          end else begin
            state_q <= StRemCheck;
          end
        end
        StRemCheck: begin
          if (nk_rdata == key_q) begin
            next_q  <= nl_rdata;
            state_q <= StRemUnlink;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= nl_rdata;
            steps_q <= steps_q + 1'b1;
            state_q <= StRemNode;
          end
        end
        StRemUnlink: state_q <= StRemFree;
        StRemFree: begin
          free_q  <= cur_q;
          if (count_q != '0) count_q <= count_q - 1'b1;
          state_q <= StResp;
        end
        StResp: begin
          if (!rsp_stall_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign req_stall_o   = (state_q != StIdle);
  assign rsp_valid_o   = (state_q == StResp);
  assign status_o      = status_q;
  assign node_index_o  = 10'(node_q);
  assign entry_count_o = 11'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= chth_pkg::CountW'(chth_pkg::Capacity))
    else $error("entry count above capacity");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && status_o == chth_pkg::StatFull) |->
      count_q == chth_pkg::CountW'(chth_pkg::Capacity))
    else $error("full reported with free nodes");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(count_q)))
    else $error("stalled result changed");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> req_stall_o)
    else $error("request taken while result pending");

endmodule

>>> design/chth_ram.sv
`timescale 1ns / 1ps
// Single-port synchronous RAM with registered read data.
module chth_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

>>> tb/chained_hash_table_insert_remove_core_tb.sv
`timescale 1ns / 1ps
module chained_hash_table_insert_remove_core_tb;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [1:0] ReqUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  logic [1:0]  req_type_i = chth_pkg::ReqAppend;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 1'b1;
  logic [1:0]  status_o;
  logic [9:0]  node_index_o;
  logic [10:0] entry_count_o;

  chained_hash_table_insert_remove_core u_dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_type_i, .key_i, .value_i,
    .rsp_valid_o, .rsp_stall_i, .status_o, .node_index_o, .entry_count_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  node;
    logic [10:0] count;
  } outcome_t;

  // Shadow copy of the table, kept in step with every accepted request.
  chth_pkg::link_t sh_bucket[chth_pkg::Capacity];
  chth_pkg::link_t sh_link[chth_pkg::Capacity];
  logic [31:0]     sh_key[chth_pkg::Capacity];
  chth_pkg::link_t sh_free;
  logic [10:0]     sh_count;

  outcome_t    pending_outcomes[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          hold_receiver = 1'b0;

  // Directed rows: request, key, value, whether the result is typed in, and
  // that result.
  typedef struct {
    logic [1:0]  req;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    outcome_t    want;
  } row_t;

  function automatic void shadow_clear();
    for (int i = 0; i < chth_pkg::Capacity; i++) begin
      sh_bucket[i] = chth_pkg::EmptyLink;
      sh_link[i]   = (i + 1 < chth_pkg::Capacity) ? chth_pkg::link_t'(i + 1)
                                                   : chth_pkg::EmptyLink;
      sh_key[i]    = '0;
    end
    sh_free  = '0;
    sh_count = '0;
  endfunction

  function automatic outcome_t predict_table(logic [1:0] req, logic [31:0] key);
    outcome_t        o;
    chth_pkg::link_t cur;
    chth_pkg::link_t prev;
    int              bkt;
    int              steps;
    o = '{status: chth_pkg::StatDone, node: '0, count: '0};
    bkt = key % chth_pkg::Capacity;
    if (req == chth_pkg::ReqAppend) begin
      if (sh_free < chth_pkg::link_t'(chth_pkg::Capacity)) begin
        cur            = sh_free;
        sh_free        = sh_link[cur];
        sh_link[cur]   = sh_bucket[bkt];
        sh_key[cur]    = key;
        sh_bucket[bkt] = cur;
        sh_count++;
        o.node = cur[9:0];
      end else begin
        o.status = chth_pkg::StatFull;
      end
    end else if (req == chth_pkg::ReqRemove) begin
      cur   = sh_bucket[bkt];
      prev  = chth_pkg::EmptyLink;
      steps = 0;
      o.status = chth_pkg::StatNotFound;
      while (cur < chth_pkg::link_t'(chth_pkg::Capacity) && steps < chth_pkg::Capacity) begin
        if (sh_key[cur] == key) begin
          if (prev < chth_pkg::link_t'(chth_pkg::Capacity)) sh_link[prev] = sh_link[cur];
          else sh_bucket[bkt] = sh_link[cur];
          sh_key[cur]  = '0;
          sh_link[cur] = sh_free;
          sh_free      = cur;
          if (sh_count > 0) sh_count--;
          o.status = chth_pkg::StatDone;
          break;
        end
        prev = cur;
        cur  = sh_link[cur];
        steps++;
      end
    end else if (req == chth_pkg::ReqClear) begin
      shadow_clear();
    end
    o.count = sh_count;
    return o;
  endfunction

  // Drives one request at the falling edge and waits for its acceptance.
  task automatic send_request(logic [1:0] req, logic [31:0] key, logic [31:0] value,
                              bit typed, outcome_t want);
    outcome_t o;
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i  <= req;
    key_i       <= key;
    value_i     <= value;
    do @(posedge clk_i); while (req_stall_o);
    o = predict_table(req, key);
    if (typed && o !== want) begin
      $error("directed row disagrees with predictor: %h vs %h", want, o);
      fail_count++;
    end
    pending_outcomes.push_back(o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    // Every clear has already finished its sweep; this wait only idles the bench before the next phase.
    repeat (chth_pkg::Capacity + 20) @(negedge clk_i);
  endtask

  // Random request: mostly appends and removes on a small key set.
  task automatic send_random(int key_span);
    logic [1:0]  req;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) req = chth_pkg::ReqAppend;
    else if (pick < 94) req = chth_pkg::ReqRemove;
    else if (pick < 97) req = ReqUnused;
    else req = chth_pkg::ReqClear;
    if ($urandom_range(0, 9) == 0) key = $urandom();
    else key = {22'($urandom_range(0, key_span)), 10'($urandom_range(0, 7))} ^
               ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0);
    send_request(req, key, $urandom(), 1'b0, '0);
  endtask

  // Receiver: stalls a random number of cycles per result, or a long stretch
  // when asked.
  initial begin
    outcome_t want;
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        rsp_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_receiver = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        rsp_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      rsp_stall_i <= 1'b0;
      do @(posedge clk_i); while (!rsp_valid_o);
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (node_index_o !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, node_index_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no request and no result accepted.
  always @(posedge clk_i) begin
    if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    shadow_clear();
    dir_rows = '{
      '{chth_pkg::ReqRemove, 32'h0, 32'h0, 1'b1,
        '{chth_pkg::StatNotFound, 10'd0, 11'd0}},
      '{chth_pkg::ReqAppend, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
        '{chth_pkg::StatDone, 10'd0, 11'd1}},
      '{chth_pkg::ReqAppend, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
        '{chth_pkg::StatDone, 10'd1, 11'd2}},
      '{chth_pkg::ReqAppend, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1,
        '{chth_pkg::StatDone, 10'd2, 11'd3}},
      '{chth_pkg::ReqAppend, 32'h0, 32'h0, 1'b1,
        '{chth_pkg::StatDone, 10'd3, 11'd4}},
      // Duplicate key: the newest copy goes first and is removed first.
      '{chth_pkg::ReqAppend, 32'h0, 32'h1234_5678, 1'b0, '0},
      '{chth_pkg::ReqAppend, 32'h400, 32'h5, 1'b0, '0},
      '{chth_pkg::ReqRemove, 32'h0, 32'h0, 1'b0, '0},
      '{chth_pkg::ReqRemove, 32'h400, 32'h0, 1'b0, '0},
      '{chth_pkg::ReqRemove, 32'h0, 32'h0, 1'b0, '0},
      '{chth_pkg::ReqRemove, 32'h0, 32'h0, 1'b0, '0},
      '{chth_pkg::ReqRemove, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
      '{ReqUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{chth_pkg::ReqAppend, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{chth_pkg::ReqAppend, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{chth_pkg::ReqClear, 32'h0, 32'h0, 1'b1,
        '{chth_pkg::StatDone, 10'd0, 11'd0}},
      '{chth_pkg::ReqAppend, 32'h3FF, 32'h1, 1'b1,
        '{chth_pkg::StatDone, 10'd0, 11'd1}}
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i])
      send_request(dir_rows[i].req, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].want);

    // Random traffic with a long receiver hold-off while requests keep coming.
    for (int n = 0; n < 200; n++) begin
      if (n == 60) hold_receiver = 1'b1;
      send_random(15);
    end
    // Pause until every outstanding result is back.
    drain_results();

    // Dense traffic on a few keys, then a clear and a wider key set.
    for (int n = 0; n < 40; n++) send_random(3);
    send_request(chth_pkg::ReqClear, '0, '0, 1'b0, '0);
    for (int n = 0; n < 190; n++) send_random(31);

    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/chth_pkg.sv
design/chth_ram.sv
design/chained_hash_table_insert_remove_core.sv
tb/chained_hash_table_insert_remove_core_tb.sv
